// ===== rtl/qsil_pkg.sv =====
// Shared widths and the quarter-wave sine table for the interpolating sine lookup.
package qsil_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int ROM_W       = 15;
	localparam int PHASE_W     = 16;
	localparam int POINT_W     = 8;
	localparam int FRAC_W      = 8;
	localparam int SAMPLE_W    = 16;
	localparam int WEIGHT_W    = FRAC_W + 1;
	localparam int PROD_W      = SAMPLE_W + WEIGHT_W + 1;

	typedef logic [POINT_W-1:0]         point_t;
	typedef logic [FRAC_W-1:0]          frac_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [PROD_W-1:0]   prod_t;

	localparam logic [ROM_W-1:0] QSIL_ROM [TABLE_DEPTH] = '{
		15'd0,     15'd804,   15'd1607,  15'd2410,  15'd3211,  15'd4011,  15'd4807,  15'd5601,
		15'd6392,  15'd7179,  15'd7961,  15'd8739,  15'd9511,  15'd10278, 15'd11038, 15'd11792,
		15'd12539, 15'd13278, 15'd14009, 15'd14732, 15'd15446, 15'd16150, 15'd16845, 15'd17530,
		15'd18204, 15'd18867, 15'd19519, 15'd20159, 15'd20787, 15'd21402, 15'd22004, 15'd22594,
		15'd23169, 15'd23731, 15'd24278, 15'd24811, 15'd25329, 15'd25831, 15'd26318, 15'd26789,
		15'd27244, 15'd27683, 15'd28105, 15'd28510, 15'd28897, 15'd29268, 15'd29621, 15'd29955,
		15'd30272, 15'd30571, 15'd30851, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31970,
		15'd32137, 15'd32284, 15'd32412, 15'd32520, 15'd32609, 15'd32678, 15'd32727, 15'd32757
	};

endpackage

// ===== rtl/qsil_point.sv =====
// Quadrant fold and signed table read for one phase point.
module qsil_point (
	input  qsil_pkg::point_t  point,
	output qsil_pkg::sample_t value
);
	import qsil_pkg::*;

	logic [IDX_W-1:0] idx;
	logic [ROM_W-1:0] mag;
	sample_t          mag_ext;

	// Mirror the index in the second and fourth quadrants, negate in the lower half.
	assign idx     = point[POINT_W-2] ? ~point[IDX_W-1:0] : point[IDX_W-1:0];
	assign mag     = QSIL_ROM[idx];
	assign mag_ext = sample_t'({1'b0, mag});
	assign value   = point[POINT_W-1] ? -mag_ext : mag_ext;

endmodule

// ===== rtl/quarter_sine_interp_lookup.sv =====
// Top level of the interpolating quarter-wave sine lookup pipeline.
//
//  channel   handshake                    payload
//  input     phase_valid / phase_ready    phase  [15:0] unsigned
//  output    sample_valid / sample_ready  sample [15:0] signed
//
// Four register stages: point split, table read, weighting multiply, sum and scale.
// Sample valid rises when the phase reaches the last stage; one item per cycle unless sample_ready stalls the pipe.
// Reset clears the stage valid bits only.
// A stall holds every full stage; an empty stage still fills, so bubbles close up.
module quarter_sine_interp_lookup (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      phase_valid,
	output logic                      phase_ready,
	input  logic [15:0]               phase,
	output logic                      sample_valid,
	input  logic                      sample_ready,
	output qsil_pkg::sample_t         sample
);
	import qsil_pkg::*;

	logic    v_s1, v_s2, v_s3, v_s4;
	logic    en_s1, en_s2, en_s3, en_s4;
	point_t  p0_s1, p1_s1;
	frac_t   f_s1, f_s2;
	sample_t a_s2, b_s2;
	sample_t a_pt, b_pt;
	prod_t   pa_s3, pb_s3;
	prod_t   sum, sum_adj;
	sample_t sample_s4;
	logic [WEIGHT_W-1:0] wa;

	assign en_s4       = !v_s4 || sample_ready;
	assign en_s3       = !v_s3 || en_s4;
	assign en_s2       = !v_s2 || en_s3;
	assign en_s1       = !v_s1 || en_s2;
	assign phase_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= phase_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Split the phase; the second point wraps from the last point to the first.
	always_ff @(posedge clk) begin
		if (en_s1 && phase_valid) begin
			p0_s1 <= phase[PHASE_W-1:FRAC_W];
			p1_s1 <= phase[PHASE_W-1:FRAC_W] + point_t'(1);
			f_s1  <= phase[FRAC_W-1:0];
		end
	end

	qsil_point u_point_a (.point(p0_s1), .value(a_pt));
	qsil_point u_point_b (.point(p1_s1), .value(b_pt));

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			a_s2 <= a_pt;
			b_s2 <= b_pt;
			f_s2 <= f_s1;
		end
	end

	assign wa = WEIGHT_W'(1 << FRAC_W) - {1'b0, f_s2};

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			pa_s3 <= prod_t'(a_s2) * prod_t'($signed({1'b0, wa}));
			pb_s3 <= prod_t'(b_s2) * prod_t'($signed({2'b00, f_s2}));
		end
	end

	// Divide by the full weight, truncating toward zero.
	assign sum     = pa_s3 + pb_s3;
	assign sum_adj = sum + (sum[PROD_W-1] ? prod_t'((1 << FRAC_W) - 1) : prod_t'(0));

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			sample_s4 <= sum_adj[FRAC_W+SAMPLE_W-1:FRAC_W];
		end
	end

	assign sample_valid = v_s4;
	assign sample       = sample_s4;

endmodule

// ===== tb/sv/quarter_sine_interp_lookup_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the interpolating quarter-wave sine lookup.
module quarter_sine_interp_lookup_test;

	localparam int RANDOM_ITEMS = 1400;
	localparam int LONG_HOLD    = 100;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum logic [1:0] {
		QUAD_RISE,
		QUAD_FALL,
		QUAD_NEG_RISE,
		QUAD_NEG_FALL
	} quadrant_e;

	typedef enum int {
		CHECK_OK,
		CHECK_UNEXPECTED,
		CHECK_WRONG
	} check_status_e;

	class sample_scoreboard;
		qsil_pkg::sample_t expected_samples[$];

		function int fold_point(qsil_pkg::point_t p);
			quadrant_e quad;
			logic [5:0] off;
			int mag;
			quad = quadrant_e'(p[7:6]);
			off  = p[5:0];
			case (quad)
				QUAD_RISE:     mag = int'(qsil_pkg::QSIL_ROM[off]);
				QUAD_FALL:     mag = int'(qsil_pkg::QSIL_ROM[6'd63 - off]);
				QUAD_NEG_RISE: mag = -int'(qsil_pkg::QSIL_ROM[off]);
				default:       mag = -int'(qsil_pkg::QSIL_ROM[6'd63 - off]);
			endcase
			return mag;
		endfunction

		function qsil_pkg::sample_t predict_sample(logic [15:0] ph);
			qsil_pkg::point_t p0;
			qsil_pkg::point_t p1;
			int fw;
			int a;
			int b;
			int sum;
			p0  = ph[15:8];
			p1  = p0 + 8'd1;
			fw  = int'(ph[7:0]);
			a   = fold_point(p0);
			b   = fold_point(p1);
			sum = a * (256 - fw) + b * fw;
			return qsil_pkg::sample_t'(sum / 256);
		endfunction

		function void note_phase(logic [15:0] ph);
			expected_samples.push_back(predict_sample(ph));
		endfunction

		function check_status_e check_sample(qsil_pkg::sample_t got,
			output qsil_pkg::sample_t want);
			want = '0;
			if (expected_samples.size() == 0)
				return CHECK_UNEXPECTED;
			want = expected_samples.pop_front();
			return (got === want) ? CHECK_OK : CHECK_WRONG;
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction
	endclass

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              phase_valid  = 1'b0;
	logic              phase_ready;
	logic [15:0]       phase        = 16'h0000;
	logic              sample_valid;
	logic              sample_ready = 1'b0;
	qsil_pkg::sample_t sample;

	sample_scoreboard sine_board = new;
	int  mismatches    = 0;
	int  cycles        = 0;
	bit  idle_on       = 1'b1;
	bit  stall_request = 1'b0;

	quarter_sine_interp_lookup u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.phase_valid  (phase_valid),
		.phase_ready  (phase_ready),
		.phase        (phase),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d samples outstanding",
				cycles, sine_board.pending());
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		check_status_e status;
		qsil_pkg::sample_t want;
		if (arst_n) begin
			if (phase_valid && phase_ready)
				sine_board.note_phase(phase);
			if (sample_valid && sample_ready) begin
				status = sine_board.check_sample(sample, want);
				if (status == CHECK_UNEXPECTED)
					report_mismatch($sformatf("sample %0d with none expected", sample));
				else if (status == CHECK_WRONG)
					report_mismatch($sformatf("sample got %0d want %0d", sample, want));
			end
		end
	end

	function automatic int draw_gap();
		return idle_on ? $urandom_range(7, 0) : 0;
	endfunction

	function automatic logic [15:0] random_phase();
		logic [7:0] edge_points [8] = '{8'd0, 8'd63, 8'd64, 8'd127,
			8'd128, 8'd191, 8'd192, 8'd255};
		logic [7:0] edge_fracs [4] = '{8'd0, 8'd1, 8'd128, 8'd255};
		logic [15:0] ph;
		ph = 16'($urandom_range(16'hFFFF, 0));
		if ($urandom_range(7, 0) == 0)
			ph[15:8] = edge_points[3'($urandom_range(7, 0))];
		if ($urandom_range(7, 0) == 0)
			ph[7:0] = edge_fracs[2'($urandom_range(3, 0))];
		return ph;
	endfunction

	task automatic send_phase(input logic [15:0] ph);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			phase_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		phase_valid <= 1'b1;
		phase       <= ph;
		do @(posedge clk); while (!phase_ready);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_phase(random_phase());
	endtask

	task automatic wait_drained();
		phase_valid <= 1'b0;
		@(posedge clk);
		while (sine_board.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (stall_request) begin
				sample_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				stall_request = 1'b0;
			end
			gap = draw_gap();
			if (gap > 0) begin
				sample_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			sample_ready <= 1'b1;
			do @(posedge clk); while (!sample_valid);
		end
	end

	initial begin
		static logic [15:0] directed [22] = '{
			16'h0000, 16'hFFFF, 16'hFF00, 16'hFF80, 16'h8000, 16'h7F80,
			16'h7FFF, 16'h3F00, 16'h3FFF, 16'h4000, 16'h40FF, 16'hBFFF,
			16'hC000, 16'hC0C0, 16'h0001, 16'h00FF, 16'h8080, 16'h3F80,
			16'h5A00, 16'hAAAA, 16'h5555, 16'h8001
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_phase(directed[i]);
		send_random(500);

		wait_drained();
		idle_on = 1'b0;
		send_random(300);

		stall_request = 1'b1;
		send_random(150);

		idle_on = 1'b1;
		send_random(RANDOM_ITEMS - 950);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
